/* rtl/rgb_to_hsv_converter_unit_assert.svh */
// Assertion macros shared by the converter RTL.
`ifndef RGB_TO_HSV_CONVERTER_UNIT_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_UNIT_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define RHC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define RHC_ASSERT_IMPL(lbl, ante, cons, msg) \
  `RHC_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

/* rtl/rgb2hsv_pkg.sv */
`timescale 1ns / 1ps

package rgb2hsv_pkg;

  localparam int CompBits = 8;
  localparam int HueBits  = 16;
  localparam int SatBits  = 8;

  localparam int DivBits    = CompBits + 3;
  localparam int NumBits    = CompBits + 4;
  localparam int SatNumBits = CompBits + SatBits;

  typedef struct packed {
    logic [CompBits-1:0] red;
    logic [CompBits-1:0] green;
    logic [CompBits-1:0] blue;
  } rgb_pix_t;

  typedef struct packed {
    logic [HueBits-1:0]  hue;
    logic [SatBits-1:0]  saturation;
    logic [CompBits-1:0] brightness;
  } hsv_pix_t;

endpackage

/* rtl/rgb_to_hsv_converter_unit.sv */
`timescale 1ns / 1ps

// RGB to HSV pixel converter. One pixel request is taken on every clock
// in which start is high; busy is always low, so the block never holds
// off a request. Each result appears on hsv_o for exactly one cycle,
// marked by done_o, once the request has passed the input register, the
// operand stage and the divider stages. The two restoring dividers share
// one pipeline producing one hue quotient bit (and, in the first stages,
// one saturation quotient bit) per stage. Results leave in request order.
// Grey pixels return zero hue and saturation; brightness is the largest
// component.
module rgb_to_hsv_converter_unit (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  rgb2hsv_pkg::rgb_pix_t pixel_i,
  output logic                  done_o,
  output rgb2hsv_pkg::hsv_pix_t hsv_o
);

`include "rgb_to_hsv_converter_unit_assert.svh"

  localparam int Cw  = rgb2hsv_pkg::CompBits;
  localparam int Hw  = rgb2hsv_pkg::HueBits;
  localparam int Sw  = rgb2hsv_pkg::SatBits;
  localparam int Dw  = rgb2hsv_pkg::DivBits;
  localparam int Nw  = rgb2hsv_pkg::NumBits;
  localparam int Snw = rgb2hsv_pkg::SatNumBits;

  // Input register.
  logic                  in_vld_q;
  rgb2hsv_pkg::rgb_pix_t in_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start & ~busy) begin
      in_q <= pixel_i;
    end
  end

  // Prepare divider operands.
  logic [Cw-1:0]        hi_d, lo_d, delta_d;
  logic [Dw-1:0]        d6_d, num_d;
  logic [Snw-1:0]       snum_d;
  logic                 grey_d;
  logic signed [Nw-1:0] diff_s, base_s, sum_s;

  always_comb begin
    hi_d = (in_q.red > in_q.green) ? in_q.red : in_q.green;
    hi_d = (hi_d > in_q.blue) ? hi_d : in_q.blue;
    lo_d = (in_q.red < in_q.green) ? in_q.red : in_q.green;
    lo_d = (lo_d < in_q.blue) ? lo_d : in_q.blue;
    delta_d = hi_d - lo_d;
    grey_d  = (delta_d == '0);
    d6_d    = ({3'b000, delta_d} << 2) + ({3'b000, delta_d} << 1);
    snum_d  = {delta_d, {Sw{1'b0}}} - {{Sw{1'b0}}, delta_d};
    if (in_q.red == hi_d) begin
      base_s = '0;
      diff_s = $signed({4'b0000, in_q.green}) - $signed({4'b0000, in_q.blue});
    end else if (in_q.green == hi_d) begin
      base_s = $signed({4'b0000, delta_d} << 1);
      diff_s = $signed({4'b0000, in_q.blue}) - $signed({4'b0000, in_q.red});
    end else begin
      base_s = $signed({4'b0000, delta_d} << 2);
      diff_s = $signed({4'b0000, in_q.red}) - $signed({4'b0000, in_q.green});
    end
    sum_s = base_s + diff_s;
    if (sum_s < 0) begin
      sum_s = sum_s + $signed({1'b0, d6_d});
    end
    num_d = sum_s[Dw-1:0];
  end

  // Divider pipeline: stage 0 holds operands, stage Hw the finished quotients.
  logic [Hw:0]    vld_q;
  logic [Cw-1:0]  hi_q   [Hw+1];
  logic [Dw-1:0]  d6_q   [Hw+1];
  logic [Dw-1:0]  hrem_q [Hw+1];
  logic [Hw-1:0]  hq_q   [Hw+1];
  logic [Snw-1:0] srem_q [Hw+1];
  logic [Sw-1:0]  sq_q   [Hw+1];
  logic [Hw:0]    grey_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Hw-1:0], in_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q[0]   <= hi_d;
    d6_q[0]   <= d6_d;
    hrem_q[0] <= num_d;
    hq_q[0]   <= '0;
    srem_q[0] <= snum_d;
    sq_q[0]   <= '0;
    grey_q[0] <= grey_d;
  end

  for (genvar k = 0; k < Hw; k++) begin : g_div
    logic [Dw:0]    hrem2;
    logic           hge;
    logic [Snw-1:0] sdiv;
    logic           sge;

    assign hrem2 = {hrem_q[k], 1'b0};
    assign hge   = (hrem2 >= {1'b0, d6_q[k]});

    if (k < Sw) begin : g_sat
      assign sdiv = {{Sw{1'b0}}, hi_q[k]} << (Sw - 1 - k);
      assign sge  = (srem_q[k] >= sdiv);
    end else begin : g_sat_idle
      assign sdiv = '0;
      assign sge  = 1'b0;
    end

    always_ff @(posedge clk_i) begin
      hi_q[k+1]   <= hi_q[k];
      d6_q[k+1]   <= d6_q[k];
      grey_q[k+1] <= grey_q[k];
      hrem_q[k+1] <= hge ? Dw'(hrem2 - {1'b0, d6_q[k]}) : hrem2[Dw-1:0];
      hq_q[k+1]   <= {hq_q[k][Hw-2:0], hge};
      if (k < Sw) begin
        srem_q[k+1] <= sge ? (srem_q[k] - sdiv) : srem_q[k];
        sq_q[k+1]   <= {sq_q[k][Sw-2:0], sge};
      end else begin
        srem_q[k+1] <= srem_q[k];
        sq_q[k+1]   <= sq_q[k];
      end
    end
  end

  assign done_o           = vld_q[Hw];
  assign hsv_o.hue        = grey_q[Hw] ? '0 : hq_q[Hw];
  assign hsv_o.saturation = grey_q[Hw] ? '0 : sq_q[Hw];
  assign hsv_o.brightness = hi_q[Hw];

  `RHC_ASSERT_IMPL(a_latency, done_o, $past(start & ~busy, Hw + 2), "result without request")
  `RHC_ASSERT_IMPL(a_value, done_o, hsv_o.brightness == $past(hi_d, Hw + 1), "brightness mismatch")
  `RHC_ASSERT(a_never_busy, busy == 1'b0, "busy raised")

endmodule

/* dv/tb_rgb_to_hsv_converter_unit.sv */
`timescale 1ns / 1ps

module tb_rgb_to_hsv_converter_unit;

  typedef rgb2hsv_pkg::rgb_pix_t rgb_pix_t;
  typedef rgb2hsv_pkg::hsv_pix_t hsv_pix_t;

  localparam int CompBits    = rgb2hsv_pkg::CompBits;
  localparam int HueBits     = rgb2hsv_pkg::HueBits;
  localparam int SatBits     = rgb2hsv_pkg::SatBits;
  localparam int CompMax     = (1 << CompBits) - 1;
  localparam int SatScale    = (1 << SatBits) - 1;
  localparam int NumRequests = 1500;
  localparam int DrainCycles = HueBits + 8;
  localparam int IdleLimit   = 2000;

  class hsv_scoreboard;
    hsv_pix_t    expected_hsv_q[$];
    int unsigned mismatches = 0;

    function hsv_pix_t convert_pixel(rgb_pix_t p);
      longint   r;
      longint   g;
      longint   b;
      longint   hi;
      longint   lo;
      longint   delta;
      longint   num;
      hsv_pix_t h;
      r = longint'(p.red);
      g = longint'(p.green);
      b = longint'(p.blue);
      hi = (r > g) ? r : g;
      hi = (hi > b) ? hi : b;
      lo = (r < g) ? r : g;
      lo = (lo < b) ? lo : b;
      delta = hi - lo;
      h.brightness = CompBits'(hi);
      if (delta == 0) begin
        h.hue = '0;
        h.saturation = '0;
      end else begin
        h.saturation = SatBits'((SatScale * delta) / hi);
        if (r == hi) begin
          num = g - b;
        end else if (g == hi) begin
          num = 2 * delta + b - r;
        end else begin
          num = 4 * delta + r - g;
        end
        if (num < 0) num += 6 * delta;
        h.hue = HueBits'((num << HueBits) / (6 * delta));
      end
      return h;
    endfunction

    function void note_request(rgb_pix_t p);
      expected_hsv_q.push_back(convert_pixel(p));
    endfunction

    function int pending();
      return expected_hsv_q.size();
    endfunction

    task report(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_result(hsv_pix_t got);
      hsv_pix_t want;
      if (expected_hsv_q.size() == 0) begin
        report($sformatf("result with no request pending: %h", got));
      end else begin
        want = expected_hsv_q.pop_front();
        if (got.hue !== want.hue)
          report($sformatf("hue got %0d want %0d", got.hue, want.hue));
        if (got.saturation !== want.saturation)
          report($sformatf("saturation got %0d want %0d", got.saturation, want.saturation));
        if (got.brightness !== want.brightness)
          report($sformatf("brightness got %0d want %0d", got.brightness, want.brightness));
      end
    endtask
  endclass

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  rgb_pix_t pixel_i = '0;
  logic     done_o;
  hsv_pix_t hsv_o;

  hsv_scoreboard hsv_sb = new();
  int            idle_cycles = 0;

  rgb_to_hsv_converter_unit u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .pixel_i (pixel_i),
    .done_o  (done_o),
    .hsv_o   (hsv_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) hsv_sb.note_request(pixel_i);
      if (done_o) hsv_sb.check_result(hsv_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic rgb_pix_t mk_pixel(int r, int g, int b);
    rgb_pix_t p;
    p.red = CompBits'(r);
    p.green = CompBits'(g);
    p.blue = CompBits'(b);
    return p;
  endfunction

  function automatic rgb_pix_t random_pixel();
    int r;
    int g;
    int b;
    int lvl;
    int mode;
    mode = $urandom_range(0, 9);
    r = $urandom_range(0, CompMax);
    g = $urandom_range(0, CompMax);
    b = $urandom_range(0, CompMax);
    case (mode)
      0: begin
        g = r;
        b = r;
      end
      1: begin
        case ($urandom_range(0, 2))
          0: g = r;
          1: b = g;
          default: b = r;
        endcase
      end
      2: begin
        lvl = $urandom_range(0, CompMax - 2);
        r = lvl + $urandom_range(0, 2);
        g = lvl + $urandom_range(0, 2);
        b = lvl + $urandom_range(0, 2);
      end
      default: ;
    endcase
    return mk_pixel(r, g, b);
  endfunction

  task automatic send_pixel(rgb_pix_t p);
    start <= 1'b1;
    pixel_i <= p;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic hold_off(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (hsv_sb.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    int  sent;
    int  burst;
    int  gap;
    bit  paused;
    sent = 0;
    paused = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_pixel(mk_pixel(0, 0, 0));
    send_pixel(mk_pixel(CompMax, CompMax, CompMax));
    send_pixel(mk_pixel(128, 128, 128));
    send_pixel(mk_pixel(CompMax, 0, 0));
    send_pixel(mk_pixel(0, CompMax, 0));
    send_pixel(mk_pixel(0, 0, CompMax));
    send_pixel(mk_pixel(CompMax, CompMax, 0));
    send_pixel(mk_pixel(0, CompMax, CompMax));
    send_pixel(mk_pixel(CompMax, 0, CompMax));
    send_pixel(mk_pixel(CompMax, 0, 1));
    send_pixel(mk_pixel(CompMax, 0, CompMax - 1));
    send_pixel(mk_pixel(1, 0, 0));
    send_pixel(mk_pixel(0, 0, 1));
    send_pixel(mk_pixel(CompMax, CompMax - 1, CompMax - 1));
    send_pixel(mk_pixel(10, 200, 100));
    send_pixel(mk_pixel(100, 10, 200));
    send_pixel(mk_pixel(200, 100, 10));
    send_pixel(mk_pixel(CompMax - 1, CompMax, CompMax - 1));
    send_pixel(mk_pixel(1, 2, CompMax));
    send_pixel(mk_pixel(2, 1, CompMax));
    hold_off(3);

    while (sent < NumRequests) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        send_pixel(random_pixel());
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) hold_off(gap);
      if (!paused && sent >= NumRequests / 2) begin
        if (gap == 0) start <= 1'b0;
        drain();
        paused = 1'b1;
      end
    end

    start <= 1'b0;
    drain();
    repeat (DrainCycles) @(posedge clk_i);
    if (hsv_sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
